// ===== rtl/core/packet_flow_hash_key_core_defines.svh =====
// Assertion macros shared by the checker of the packet flow hash key core.
`ifndef PACKET_FLOW_HASH_KEY_CORE_DEFINES_SVH
`define PACKET_FLOW_HASH_KEY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define PFHK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfhk check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define PFHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfhk check failed");

`endif

// ===== rtl/core/pfhk_pkg.sv =====
// Package with constants, types and the frame record of the flow hash key core.
`timescale 1ns / 1ps
package pfhk_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [31:0] COOKIE_VAL = 32'h63825363;
    localparam logic [7:0]  HW_TYPE_ETH = 8'd1;
    localparam logic [7:0]  HW_LEN_ETH = 8'd6;

    localparam int ETYPE_AT = 12;
    localparam int IHL_AT = 14;
    localparam int PROTO_AT = 23;
    localparam int SRC_AT = 26;
    localparam int DST_AT = 30;
    localparam int ETH_HDR = 14;
    localparam int UDP_HDR = 8;
    localparam int MIN_FRAME = 34;
    localparam int DHCP_MIN = 244;
    localparam int HWTYPE_AT = 1;
    localparam int HWLEN_AT = 2;
    localparam int CLIENT_AT = 30;
    localparam int COOKIE_AT = 236;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_XOR  = 2'd1,
        KEY_DHCP = 2'd2
    } key_src_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] client_word;
        key_src_t    kind;
    } frame_rec_t;

endpackage

// ===== rtl/core/pfhk_front.sv =====
// Front end: counts frame bytes, captures header fields and classifies each frame.
`timescale 1ns / 1ps
module pfhk_front #(
    parameter int COUNT_BITS = pfhk_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [7:0]           packet_byte,
    input  logic                 last_byte,
    output logic                 rec_push,
    output pfhk_pkg::frame_rec_t rec_data
);
    import pfhk_pkg::*;

    localparam int CW = COUNT_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   ether_kind_reg, ether_kind_next, ether_kind_cap;
    logic [7:0]    ip_proto_reg, ip_proto_next, ip_proto_cap;
    logic [3:0]    header_words_reg, header_words_next, header_words_cap;
    logic [31:0]   source_addr_reg, source_addr_next, source_addr_cap;
    logic [31:0]   dest_addr_reg, dest_addr_next, dest_addr_cap;
    logic [7:0]    hw_type_reg, hw_type_next, hw_type_cap;
    logic [7:0]    hw_len_reg, hw_len_next, hw_len_cap;
    logic [31:0]   cookie_word_reg, cookie_word_next, cookie_word_cap;
    logic [31:0]   client_word_reg, client_word_next, client_word_cap;

    logic [CW-1:0] pos;
    logic [CW-1:0] dhcp_at;
    logic          frame_end;
    logic          is_ipv4;
    logic          is_dhcp;

    assign pos = count_reg;
    assign dhcp_at = CW'(ETH_HDR + UDP_HDR) + CW'({header_words_reg, 2'b00});
    assign frame_end = byte_valid && last_byte;

    always_comb
    begin
        ether_kind_cap = ether_kind_reg;
        ip_proto_cap = ip_proto_reg;
        header_words_cap = header_words_reg;
        source_addr_cap = source_addr_reg;
        dest_addr_cap = dest_addr_reg;
        hw_type_cap = hw_type_reg;
        hw_len_cap = hw_len_reg;
        cookie_word_cap = cookie_word_reg;
        client_word_cap = client_word_reg;
        if (pos >= CW'(ETYPE_AT) && pos < CW'(ETYPE_AT + 2))
        begin
            ether_kind_cap = {ether_kind_reg[7:0], packet_byte};
        end
        if (pos == CW'(IHL_AT))
        begin
            header_words_cap = packet_byte[3:0];
        end
        if (pos == CW'(PROTO_AT))
        begin
            ip_proto_cap = packet_byte;
        end
        if (pos >= CW'(SRC_AT) && pos < CW'(SRC_AT + 4))
        begin
            source_addr_cap = {source_addr_reg[23:0], packet_byte};
        end
        if (pos >= CW'(DST_AT) && pos < CW'(DST_AT + 4))
        begin
            dest_addr_cap = {dest_addr_reg[23:0], packet_byte};
        end
        if (pos == dhcp_at + CW'(HWTYPE_AT))
        begin
            hw_type_cap = packet_byte;
        end
        if (pos == dhcp_at + CW'(HWLEN_AT))
        begin
            hw_len_cap = packet_byte;
        end
        if (pos >= dhcp_at + CW'(CLIENT_AT) && pos < dhcp_at + CW'(CLIENT_AT + 4))
        begin
            client_word_cap = {client_word_reg[23:0], packet_byte};
        end
        if (pos >= dhcp_at + CW'(COOKIE_AT) && pos < dhcp_at + CW'(COOKIE_AT + 4))
        begin
            cookie_word_cap = {cookie_word_reg[23:0], packet_byte};
        end
    end

    assign is_ipv4 = (pos >= CW'(MIN_FRAME - 1)) && (ether_kind_cap == ETH_IPV4);
    assign is_dhcp = (ip_proto_cap == PROTO_UDP)
                     && (pos >= dhcp_at + CW'(DHCP_MIN - 1))
                     && (hw_type_cap == HW_TYPE_ETH)
                     && (hw_len_cap == HW_LEN_ETH)
                     && (cookie_word_cap == COOKIE_VAL);

    always_comb
    begin
        rec_push = frame_end;
        rec_data.src_addr = source_addr_cap;
        rec_data.dst_addr = dest_addr_cap;
        rec_data.client_word = client_word_cap;
        if (!is_ipv4)
        begin
            rec_data.kind = KEY_NONE;
        end
        else if (is_dhcp)
        begin
            rec_data.kind = KEY_DHCP;
        end
        else
        begin
            rec_data.kind = KEY_XOR;
        end

        count_next = count_reg;
        ether_kind_next = ether_kind_reg;
        ip_proto_next = ip_proto_reg;
        header_words_next = header_words_reg;
        source_addr_next = source_addr_reg;
        dest_addr_next = dest_addr_reg;
        hw_type_next = hw_type_reg;
        hw_len_next = hw_len_reg;
        cookie_word_next = cookie_word_reg;
        client_word_next = client_word_reg;
        if (frame_end)
        begin
            count_next = '0;
            ether_kind_next = '0;
            ip_proto_next = '0;
            header_words_next = '0;
            source_addr_next = '0;
            dest_addr_next = '0;
            hw_type_next = '0;
            hw_len_next = '0;
            cookie_word_next = '0;
            client_word_next = '0;
        end
        else if (byte_valid)
        begin
            count_next = (count_reg != '1) ? count_reg + CW'(1) : count_reg;
            ether_kind_next = ether_kind_cap;
            ip_proto_next = ip_proto_cap;
            header_words_next = header_words_cap;
            source_addr_next = source_addr_cap;
            dest_addr_next = dest_addr_cap;
            hw_type_next = hw_type_cap;
            hw_len_next = hw_len_cap;
            cookie_word_next = cookie_word_cap;
            client_word_next = client_word_cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ether_kind_reg <= '0;
            ip_proto_reg <= '0;
            header_words_reg <= '0;
            source_addr_reg <= '0;
            dest_addr_reg <= '0;
            hw_type_reg <= '0;
            hw_len_reg <= '0;
            cookie_word_reg <= '0;
            client_word_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ether_kind_reg <= ether_kind_next;
            ip_proto_reg <= ip_proto_next;
            header_words_reg <= header_words_next;
            source_addr_reg <= source_addr_next;
            dest_addr_reg <= dest_addr_next;
            hw_type_reg <= hw_type_next;
            hw_len_reg <= hw_len_next;
            cookie_word_reg <= cookie_word_next;
            client_word_reg <= client_word_next;
        end
    end

endmodule

// ===== rtl/core/pfhk_queue.sv =====
// Small queue of classified frame records between the front and back ends.
`timescale 1ns / 1ps
module pfhk_queue #(
    parameter int QUEUE_DEPTH = pfhk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pfhk_pkg::frame_rec_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output pfhk_pkg::frame_rec_t head_data
);
    import pfhk_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t     slots [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  fill_reg, fill_next;
    logic           do_push;
    logic           do_pop;

    assign full = (fill_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== rtl/core/pfhk_back.sv =====
// Back end: forms the flow key from a frame record and holds it in the output register.
`timescale 1ns / 1ps
module pfhk_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    input  pfhk_pkg::frame_rec_t rec_data,
    output logic                 rec_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          hash_key,
    output logic [1:0]           key_source
);
    import pfhk_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] key_reg, key_next;
    key_src_t    src_reg, src_next;
    logic        load;

    assign empty = !out_valid_reg;
    assign load = rec_valid && (!out_valid_reg || pop);
    assign rec_pop = load;
    assign hash_key = key_reg;
    assign key_source = src_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        key_next = key_reg;
        src_next = src_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            src_next = rec_data.kind;
            case (rec_data.kind)
                KEY_XOR:  key_next = rec_data.src_addr ^ rec_data.dst_addr;
                KEY_DHCP: key_next = rec_data.client_word;
                default:  key_next = '0;
            endcase
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        src_reg <= src_next;
    end

endmodule

// ===== rtl/core/packet_flow_hash_key_core.sv =====
// Top level of the packet flow hash key core.
//
//  Channel  Handshake       Payload                    Moves per transfer
//  input    push / full     packet_byte, last_byte     one frame byte
//  result   empty / pop     hash_key, key_source       one key per frame
//
// One byte is taken every cycle while full is low; the front end captures
// header fields as they pass and classifies the frame on its last byte.
// A key passes through the record queue and the output register before it
// shows on the result ports, and stays there until popped.
// Full rises only when the record queue and the output register are both
// occupied. Reset clears the byte counter, captures, queue and valid flag.
`timescale 1ns / 1ps
module packet_flow_hash_key_core #(
    parameter int COUNT_BITS = pfhk_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = pfhk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_key,
    output logic [1:0]  key_source
);
    import pfhk_pkg::*;

    logic       byte_valid;
    logic       rec_push;
    frame_rec_t rec_in;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    frame_rec_t q_head;

    assign full = q_full;
    assign byte_valid = push && !q_full;

    pfhk_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .rec_push    (rec_push),
        .rec_data    (rec_in)
    );

    pfhk_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_data  (rec_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    pfhk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (q_valid),
        .rec_data   (q_head),
        .rec_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .hash_key   (hash_key),
        .key_source (key_source)
    );

endmodule

// ===== rtl/core/pfhk_checker.sv =====
// Port checker for the packet flow hash key core and its bind statement.
`timescale 1ns / 1ps
`include "packet_flow_hash_key_core_defines.svh"
module pfhk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] hash_key,
    input logic [1:0]  key_source
);
    import pfhk_pkg::*;

    `PFHK_ASSERT_NOW(a_source_code, !empty, key_source <= 2'(KEY_DHCP))
    `PFHK_ASSERT_NOW(a_none_is_zero, !empty && key_source == KEY_NONE, hash_key == 32'd0)
    `PFHK_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(hash_key) && $stable(key_source))
    `PFHK_ASSERT_NEXT(a_idle_stays_empty, empty && !full && !push && $past(empty) && $past(!push), empty)

endmodule

bind packet_flow_hash_key_core pfhk_checker u_pfhk_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the packet flow hash key core with a frame-level key predictor.
`timescale 1ns / 1ps

import pfhk_pkg::*;

typedef logic [7:0] frame_bytes_t[$];

typedef struct {
    logic [31:0] key;
    key_src_t    kind;
} flow_key_t;

class flow_key_board;
    localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;

    int          byte_pos;
    logic [15:0] ether_kind;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  hw_type;
    logic [7:0]  hw_len;
    logic [31:0] cookie;
    logic [31:0] client;
    flow_key_t   keys_due[$];
    int          fails;

    function new();
        fails = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        byte_pos = 0;
        ether_kind = '0;
        proto = '0;
        ihl = '0;
        src_addr = '0;
        dst_addr = '0;
        hw_type = '0;
        hw_len = '0;
        cookie = '0;
        client = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        int pos;
        int ds;
        int len;
        flow_key_t due;
        pos = byte_pos;
        if (pos >= ETYPE_AT && pos < ETYPE_AT + 2) ether_kind = {ether_kind[7:0], b};
        if (pos == IHL_AT) ihl = b[3:0];
        if (pos == PROTO_AT) proto = b;
        if (pos >= SRC_AT && pos < SRC_AT + 4) src_addr = {src_addr[23:0], b};
        if (pos >= DST_AT && pos < DST_AT + 4) dst_addr = {dst_addr[23:0], b};
        ds = ETH_HDR + 4 * int'(ihl) + UDP_HDR;
        if (pos == ds + HWTYPE_AT) hw_type = b;
        if (pos == ds + HWLEN_AT) hw_len = b;
        if (pos >= ds + CLIENT_AT && pos < ds + CLIENT_AT + 4) client = {client[23:0], b};
        if (pos >= ds + COOKIE_AT && pos < ds + COOKIE_AT + 4) cookie = {cookie[23:0], b};
        if (byte_pos < COUNT_MAX) byte_pos++;
        if (last) begin
            len = pos + 1;
            due.key = '0;
            due.kind = KEY_NONE;
            if (len >= MIN_FRAME && ether_kind == ETH_IPV4) begin
                if (proto == PROTO_UDP && len >= ds + DHCP_MIN && hw_type == HW_TYPE_ETH
                        && hw_len == HW_LEN_ETH && cookie == COOKIE_VAL) begin
                    due.key = client;
                    due.kind = KEY_DHCP;
                end
                else begin
                    due.key = src_addr ^ dst_addr;
                    due.kind = KEY_XOR;
                end
            end
            keys_due.push_back(due);
            clear_frame();
        end
    endfunction

    function void check_key(logic [31:0] key, logic [1:0] kind);
        flow_key_t due;
        if (keys_due.size() == 0) begin
            if (fails < 10)
                $display("Unexpected key transfer: key %h source %0d", key, kind);
            fails++;
        end
        else begin
            due = keys_due.pop_front();
            if (key !== due.key || kind !== due.kind) begin
                if (fails < 10)
                    $display("Key mismatch: expected key %h source %0d, got key %h source %0d",
                             due.key, due.kind, key, kind);
                fails++;
            end
        end
    endfunction
endclass

module testbench;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [31:0] hash_key;
    logic [1:0]  key_source;

    flow_key_board board;
    bit            quiet;
    bit            hold_req;
    frame_bytes_t  frame;

    packet_flow_hash_key_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .packet_byte(packet_byte),
        .last_byte(last_byte),
        .empty(empty),
        .pop(pop),
        .hash_key(hash_key),
        .key_source(key_source)
    );

    always #4 clk = ~clk;

    function automatic void put_bytes(ref frame_bytes_t fb, input int at, input logic [31:0] v,
                                      input int n);
        for (int i = 0; i < n; i++)
            if (at + i < fb.size()) fb[at + i] = v[8 * (n - 1 - i) +: 8];
    endfunction

    function automatic void make_frame(ref frame_bytes_t fb, input int len, input int fill,
                                       input logic [15:0] etype, input logic [3:0] hdr_words,
                                       input logic [7:0] ip_proto, input logic [7:0] hwt,
                                       input logic [7:0] hwl, input logic [31:0] magic);
        int ds;
        ds = ETH_HDR + 4 * int'(hdr_words) + UDP_HDR;
        fb.delete();
        for (int i = 0; i < len; i++)
            fb.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        put_bytes(fb, ETYPE_AT, etype, 2);
        if (len > IHL_AT) fb[IHL_AT] = {fb[IHL_AT][7:4], hdr_words};
        put_bytes(fb, PROTO_AT, ip_proto, 1);
        put_bytes(fb, ds + HWTYPE_AT, hwt, 1);
        put_bytes(fb, ds + HWLEN_AT, hwl, 1);
        put_bytes(fb, ds + COOKIE_AT, magic, 4);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push <= 1'b1;
        packet_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (full);
        board.note_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (board.keys_due.size() != 0) @(posedge clk);
    endtask

    // Result side: random pop bursts, plus one long hold-off on request.
    initial begin
        int gap;
        int hold_left;
        gap = 0;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge clk);
            if (pop && !empty) board.check_key(hash_key, key_source);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (gap > 0) begin
                gap--;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int rand_bytes;
        int frames;
        int len;
        logic [3:0] hw;
        logic [15:0] etype;
        logic [7:0] ip_proto;
        logic [7:0] hwt;
        logic [7:0] hwl;
        logic [31:0] magic;
        rst_n = 1'b0;
        push = 1'b0;
        packet_byte = '0;
        last_byte = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: boundaries of length and type, and of the DHCP length.
        make_frame(frame, 1, -1, ETH_IPV4, 4'd5, PROTO_UDP, 8'd1, 8'd6, COOKIE_VAL);
        send_frame();
        make_frame(frame, 1, -1, ETH_IPV4, 4'd5, PROTO_UDP, 8'd1, 8'd6, COOKIE_VAL);
        send_frame();
        make_frame(frame, MIN_FRAME - 1, -1, ETH_IPV4, 4'd5, 8'h06, 8'd1, 8'd6, COOKIE_VAL);
        send_frame();
        make_frame(frame, MIN_FRAME, -1, 16'h0806, 4'd5, 8'h06, 8'd1, 8'd6, COOKIE_VAL);
        send_frame();
        make_frame(frame, MIN_FRAME, 8'hFF, ETH_IPV4, 4'hF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF);
        send_frame();
        make_frame(frame, 40, 8'h00, ETH_IPV4, 4'h0, 8'h00, 8'h00, 8'h00, 32'h0);
        send_frame();
        make_frame(frame, 22 + 20 + DHCP_MIN, -1, ETH_IPV4, 4'd5, PROTO_UDP, HW_TYPE_ETH,
                   HW_LEN_ETH, COOKIE_VAL);
        send_frame();
        make_frame(frame, 22 + 20 + DHCP_MIN - 1, -1, ETH_IPV4, 4'd5, PROTO_UDP, HW_TYPE_ETH,
                   HW_LEN_ETH, COOKIE_VAL);
        send_frame();
        wait_drained();

        // Result side holds off while short frames keep coming, so the core backs up.
        hold_req = 1'b1;
        for (int f = 0; f < 8; f++) begin
            make_frame(frame, MIN_FRAME, -1, ETH_IPV4, 4'd5, 8'h06, 8'd0, 8'd0, 32'h0);
            send_frame();
        end
        wait_drained();

        rand_bytes = 0;
        frames = 0;
        while (rand_bytes < 780 || frames < 10) begin
            quiet = (rand_bytes >= 620 && frames >= 8);
            hw = 4'($urandom);
            etype = ETH_IPV4;
            ip_proto = 8'($urandom);
            hwt = 8'($urandom);
            hwl = 8'($urandom);
            magic = $urandom;
            case ($urandom_range(0, 15))
                0: begin
                    len = $urandom_range(1, MIN_FRAME - 1);
                    if ($urandom_range(0, 1) == 0) etype = 16'($urandom);
                end
                1: begin
                    len = $urandom_range(MIN_FRAME, 70);
                    etype = 16'($urandom);
                end
                2, 3: begin
                    len = ETH_HDR + 4 * int'(hw) + UDP_HDR + DHCP_MIN - 2 + $urandom_range(0, 6);
                    if ($urandom_range(0, 7) != 0) ip_proto = PROTO_UDP;
                    if ($urandom_range(0, 7) != 0) hwt = HW_TYPE_ETH;
                    if ($urandom_range(0, 7) != 0) hwl = HW_LEN_ETH;
                    if ($urandom_range(0, 7) != 0) magic = COOKIE_VAL;
                end
                default: begin
                    len = $urandom_range(MIN_FRAME, 64);
                    if ($urandom_range(0, 3) == 0) ip_proto = PROTO_UDP;
                end
            endcase
            make_frame(frame, len, -1, etype, hw, ip_proto, hwt, hwl, magic);
            send_frame();
            rand_bytes += len;
            frames++;
        end

        quiet = 1'b1;
        wait_drained();
        repeat (16) @(posedge clk);
        if (board.fails == 0 && board.keys_due.size() == 0)
            $display("packet_flow_hash_key_core verification clean");
        else
            $display("packet_flow_hash_key_core verification failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("packet_flow_hash_key_core verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pfhk_pkg.sv
rtl/core/pfhk_front.sv
rtl/core/pfhk_queue.sv
rtl/core/pfhk_back.sv
rtl/core/packet_flow_hash_key_core.sv
rtl/core/pfhk_checker.sv
test/testbench.sv
